// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define PRLD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define PRLD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/prld_pkg.sv =====
// Types and constants of the pixel run-length decoder.
package prld_pkg;

   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_RUN     = 2'd1,
      MODE_LITERAL = 2'd2
   } decode_mode_type;

   typedef logic [2:0]  pixel_bytes_type;
   typedef logic [7:0]  stream_byte_type;
   typedef logic [31:0] pixel_type;
   typedef logic [7:0]  count_type;

   localparam int unsigned PIXEL_LANES = 4;
   localparam pixel_bytes_type PIXEL_BYTES_RESET = 3'd4;
   localparam count_type RUN_BIAS = 8'd3;
   localparam count_type LITERAL_BIAS = 8'd1;

endpackage

// ===== hdl/prld_req_if.sv =====
// Channel that carries compressed stream bytes into the decoder.
interface prld_req_if;
   logic                      valid;
   logic                      ready;
   prld_pkg::stream_byte_type in_byte;
   logic                      last_in;

   modport source (output valid, output in_byte, output last_in, input ready);
   modport sink (input valid, input in_byte, input last_in, output ready);
endinterface

// ===== hdl/prld_rsp_if.sv =====
// Channel that carries decoded pixels out of the decoder.
interface prld_rsp_if;
   logic                 valid;
   logic                 ready;
   prld_pkg::pixel_type  pixel;
   prld_pkg::count_type  repeat_count;
   logic                 stream_done;
   logic                 truncated;

   modport source (output valid, output pixel, output repeat_count, output stream_done,
                   output truncated, input ready);
   modport sink (input valid, input pixel, input repeat_count, input stream_done,
                 input truncated, output ready);
endinterface

// ===== hdl/pixel_run_length_decoder.sv =====
// A result is registered and appears on the response channel in the cycle after its byte beat is accepted.
// Throughput: one byte per cycle; the input side is ready while the output register is
// empty or being taken, and only a stalled full output register holds back a new beat.
// Reset (synchronous, active high) returns the decoder to header expected, clears
// the pixel gather state, empties the output register, and sets pixel_bytes to 4.
`include "assert_macros.svh"

module pixel_run_length_decoder #(
   parameter int unsigned MAX_PIXEL_BYTES = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  prld_pkg::pixel_bytes_type csr_wdata,
   prld_req_if.sink                  req_chan,
   prld_rsp_if.source                rsp_chan
);
   import prld_pkg::*;

   localparam int unsigned IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int unsigned CNT_W = IDX_W + 1;

   pixel_bytes_type pixel_bytes_ff;
   decode_mode_type mode_ff, mode_in;
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   pixel_type       accum_ff, accum_in;
   count_type       literal_left_ff, literal_left_in;
   count_type       run_length_ff, run_length_in;

   logic            rsp_valid_ff;
   pixel_type       pixel_ff, pixel_in;
   count_type       repeat_ff, repeat_in;
   logic            done_ff, done_in;
   logic            trunc_ff, trunc_in;
   logic            produce;

   logic            accept;
   logic [3:0]      width_full;
   logic [CNT_W-1:0] width_cnt;
   logic [CNT_W-1:0] byte_count;
   pixel_type       gathered;
   logic            pixel_complete;
   logic            block_end;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      if (pixel_bytes_ff == 3'd0) begin
         width_full = 4'd1;
      end else if (4'(pixel_bytes_ff) > 4'(MAX_PIXEL_BYTES)) begin
         width_full = 4'(MAX_PIXEL_BYTES);
      end else begin
         width_full = 4'(pixel_bytes_ff);
      end
   end

   assign width_cnt = width_full[CNT_W-1:0];
   assign byte_count = {1'b0, byte_index_ff} + CNT_W'(1);
   assign pixel_complete = byte_count >= width_cnt;

   always_comb begin
      gathered = accum_ff;
      for (int k = 0; k < PIXEL_LANES; k++) begin
         if (4'(byte_index_ff) == 4'(k)) begin
            gathered[8*k +: 8] = req_chan.in_byte;
         end
      end
   end

   always_comb begin
      mode_in = mode_ff;
      byte_index_in = byte_index_ff;
      accum_in = accum_ff;
      literal_left_in = literal_left_ff;
      run_length_in = run_length_ff;
      produce = 1'b0;
      pixel_in = '0;
      repeat_in = '0;
      done_in = req_chan.last_in;
      trunc_in = 1'b0;
      block_end = 1'b0;
      unique case (mode_ff)
         MODE_HEADER: begin
            if (req_chan.in_byte[7]) begin
               run_length_in = {1'b0, req_chan.in_byte[6:0]} + RUN_BIAS;
               mode_in = MODE_RUN;
            end else begin
               literal_left_in = req_chan.in_byte + LITERAL_BIAS;
               mode_in = MODE_LITERAL;
            end
            byte_index_in = '0;
            accum_in = '0;
            if (req_chan.last_in) begin
               produce = 1'b1;
               trunc_in = 1'b1;
            end
         end
         MODE_RUN, MODE_LITERAL: begin
            if (pixel_complete) begin
               produce = 1'b1;
               pixel_in = gathered;
               byte_index_in = '0;
               accum_in = '0;
               if (mode_ff == MODE_RUN) begin
                  repeat_in = run_length_ff;
                  block_end = 1'b1;
               end else begin
                  repeat_in = LITERAL_BIAS;
                  if (literal_left_ff != 8'd0) begin
                     literal_left_in = literal_left_ff - 8'd1;
                  end
                  block_end = literal_left_ff <= 8'd1;
               end
               trunc_in = req_chan.last_in && !block_end;
               if (block_end) begin
                  mode_in = MODE_HEADER;
                  literal_left_in = '0;
                  run_length_in = '0;
               end
            end else begin
               byte_index_in = byte_index_ff + IDX_W'(1);
               accum_in = gathered;
               if (req_chan.last_in) begin
                  produce = 1'b1;
                  trunc_in = 1'b1;
               end
            end
         end
         default: begin
            mode_in = MODE_HEADER;
         end
      endcase
      if (req_chan.last_in) begin
         mode_in = MODE_HEADER;
         byte_index_in = '0;
         accum_in = '0;
         literal_left_in = '0;
         run_length_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff <= PIXEL_BYTES_RESET;
      end else if (csr_we) begin
         pixel_bytes_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HEADER;
         byte_index_ff <= '0;
         accum_ff <= '0;
         literal_left_ff <= '0;
         run_length_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         byte_index_ff <= byte_index_in;
         accum_ff <= accum_in;
         literal_left_ff <= literal_left_in;
         run_length_ff <= run_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= produce;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         pixel_ff <= pixel_in;
         repeat_ff <= repeat_in;
         done_ff <= done_in;
         trunc_ff <= trunc_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel = pixel_ff;
   assign rsp_chan.repeat_count = repeat_ff;
   assign rsp_chan.stream_done = done_ff;
   assign rsp_chan.truncated = trunc_ff;

   `PRLD_ASSERT_ALWAYS(a_trunc_done, !rsp_valid_ff || !trunc_ff || done_ff,
      "truncated result without stream end")
   `PRLD_ASSERT_ALWAYS(a_empty_result,
      !rsp_valid_ff || repeat_ff != 8'd0 || (trunc_ff && pixel_ff == '0),
      "empty result that is not a truncation")
   `PRLD_ASSERT_ALWAYS(a_header_index, mode_ff != MODE_HEADER || byte_index_ff == '0,
      "byte index nonzero while a header is expected")
   `PRLD_ASSERT_NEXT(a_last_clears, accept && req_chan.last_in,
      mode_ff == MODE_HEADER && accum_ff == '0 && rsp_valid_ff,
      "state not cleared after the final beat")

endmodule
